[src/dlts_pkg.sv]
// Package for the delta-list task scheduler.
// Holds table sizes, the entry layout, opcodes, status codes and sequencer states.
// Used by dlts_alu, dlts_table and delta_list_task_scheduler.
`timescale 1ns / 1ps
`default_nettype none
package dlts_pkg;

  localparam int MAX_TASKS = 16;
  localparam int ID_BITS = 8;
  localparam int IDX_W = $clog2(MAX_TASKS);
  localparam int CNT_W = $clog2(MAX_TASKS + 1);
  localparam int DLY_W = 32;
  localparam int PEND_W = 16;
  localparam logic [PEND_W-1:0] PENDING_MAX = {PEND_W{1'b1}};

  typedef enum logic [2:0] {
    OP_CLEAR    = 3'd0,
    OP_ADD      = 3'd1,
    OP_TICK     = 3'd2,
    OP_DISPATCH = 3'd3,
    OP_DELETE   = 3'd4
  } opcode_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_FULL     = 2'd1,
    ST_NONE_DUE = 2'd2,
    ST_BAD_SLOT = 2'd3
  } status_t;

  typedef enum logic {
    ALU_SUB,
    ALU_ADD_SAT
  } alu_mode_t;

  typedef struct packed {
    alu_mode_t          mode;
    logic [DLY_W-1:0]   a;
    logic [DLY_W-1:0]   b;
  } alu_req_t;

  typedef struct packed {
    logic [ID_BITS-1:0] id;
    logic [DLY_W-1:0]   delta;
    logic [DLY_W-1:0]   period;
    logic [PEND_W-1:0]  pending;
  } entry_t;

  typedef struct packed {
    logic               rd_en;
    logic [IDX_W-1:0]   rd_addr;
    logic               wr_en;
    logic [IDX_W-1:0]   wr_addr;
    entry_t             wr_data;
  } tbl_req_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_WALK_RD,
    S_WALK_CHK,
    S_FIX,
    S_SHIFT_RD,
    S_SHIFT_WR,
    S_INS_WR,
    S_TICK_RD,
    S_TICK_WR,
    S_DISP_RD,
    S_DISP_CHK,
    S_RM_RD0,
    S_RM_RD1,
    S_RM_SUM,
    S_RM_SHRD,
    S_RM_SHWR,
    S_RM_END,
    S_DONE
  } state_t;

endpackage
`default_nettype wire

[src/dlts_alu.sv]
// Shared subtract / saturating add unit for the scheduler sequencer.
// Depends on dlts_pkg for the request struct and operand width.
`timescale 1ns / 1ps
`default_nettype none
module dlts_alu (
  input  dlts_pkg::alu_req_t                req,
  output logic [dlts_pkg::DLY_W-1:0]        res,
  output logic                              borrow
);
  import dlts_pkg::*;

  logic [DLY_W:0] diff;
  logic [DLY_W:0] sum;

  assign diff = {1'b0, req.a} - {1'b0, req.b};
  assign sum  = {1'b0, req.a} + {1'b0, req.b};

  always_comb begin
    unique case (req.mode)
      ALU_SUB: begin
        res    = diff[DLY_W-1:0];
        borrow = diff[DLY_W];
      end
      ALU_ADD_SAT: begin
        res    = sum[DLY_W] ? {DLY_W{1'b1}} : sum[DLY_W-1:0];
        borrow = 1'b0;
      end
      default: begin
        res    = diff[DLY_W-1:0];
        borrow = diff[DLY_W];
      end
    endcase
  end

endmodule
`default_nettype wire

[src/dlts_table.sv]
// Task table storage: one write port and one registered read port.
// Depends on dlts_pkg for the entry layout and request struct.
`timescale 1ns / 1ps
`default_nettype none
module dlts_table (
  input  wire logic          clk,
  input  dlts_pkg::tbl_req_t req,
  output dlts_pkg::entry_t   rd_data
);
  import dlts_pkg::*;

  entry_t mem [MAX_TASKS];
  entry_t rd_q_r;

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
    if (req.rd_en) begin
      rd_q_r <= mem[req.rd_addr];
    end
  end

  assign rd_data = rd_q_r;

endmodule
`default_nettype wire

[src/delta_list_task_scheduler.sv]
// Delta-list task scheduler top level: sequencer, table and shared arithmetic unit.
// From accept to ready again with N tasks held: clear, rejects and empty-table commands go
// straight to the result; tick rewrites the head entry and a dispatch with nothing due checks it;
// add walks and shifts entries up, delete shifts them down, and dispatch removes the head and may
// walk again to put a periodic task back. Entries walked or shifted share the one read port; one
// transaction is in work at a time. Reset clears the task count and handshakes, not the table.
`timescale 1ns / 1ps
`default_nettype none
module delta_list_task_scheduler (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       in_valid,
  output logic                            in_ready,
  input  wire logic [2:0]                 in_opcode,
  input  wire logic [7:0]                 in_task_id,
  input  wire logic [31:0]                in_first_delay,
  input  wire logic [31:0]                in_repeat_period,
  input  wire logic [3:0]                 in_slot_index,
  output logic                            out_valid,
  input  wire logic                       out_ready,
  output logic [1:0]                      out_status,
  output logic                            out_run_valid,
  output logic [7:0]                      out_run_task_id,
  output logic [4:0]                      out_task_count
);
  import dlts_pkg::*;

  state_t              state_r, state_nxt;
  logic [CNT_W-1:0]    used_r, used_nxt;
  logic [CNT_W-1:0]    pos_r, pos_nxt;
  logic [CNT_W-1:0]    k_r, k_nxt;
  logic [DLY_W-1:0]    cur_r, cur_nxt;
  logic [DLY_W-1:0]    fix_r, fix_nxt;
  logic [DLY_W-1:0]    tmp_r, tmp_nxt;
  logic [ID_BITS-1:0]  id_r, id_nxt;
  logic [DLY_W-1:0]    per_r, per_nxt;
  logic                reins_r, reins_nxt;
  status_t             st_r, st_nxt;
  logic                rv_r, rv_nxt;
  logic [7:0]          rid_r, rid_nxt;

  logic                out_valid_r, out_valid_nxt;
  logic [1:0]          out_status_r, out_status_nxt;
  logic                out_run_valid_r, out_run_valid_nxt;
  logic [7:0]          out_run_task_id_r, out_run_task_id_nxt;
  logic [4:0]          out_task_count_r, out_task_count_nxt;

  tbl_req_t            req;
  entry_t              rd_data;
  entry_t              wdata;
  alu_req_t            alu_req;
  logic [DLY_W-1:0]    alu_res;
  logic                alu_borrow;
  logic [CNT_W-1:0]    k_m1;
  logic [CNT_W-1:0]    pos_p1;

  dlts_table u_table (
    .clk     (clk),
    .req     (req),
    .rd_data (rd_data)
  );

  dlts_alu u_alu (
    .req    (alu_req),
    .res    (alu_res),
    .borrow (alu_borrow)
  );

  assign k_m1   = k_r - CNT_W'(1);
  assign pos_p1 = pos_r + CNT_W'(1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      used_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      used_r      <= used_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pos_r             <= pos_nxt;
    k_r               <= k_nxt;
    cur_r             <= cur_nxt;
    fix_r             <= fix_nxt;
    tmp_r             <= tmp_nxt;
    id_r              <= id_nxt;
    per_r             <= per_nxt;
    reins_r           <= reins_nxt;
    st_r              <= st_nxt;
    rv_r              <= rv_nxt;
    rid_r             <= rid_nxt;
    out_status_r      <= out_status_nxt;
    out_run_valid_r   <= out_run_valid_nxt;
    out_run_task_id_r <= out_run_task_id_nxt;
    out_task_count_r  <= out_task_count_nxt;
  end

  always_comb begin
    state_nxt           = state_r;
    used_nxt            = used_r;
    pos_nxt             = pos_r;
    k_nxt               = k_r;
    cur_nxt             = cur_r;
    fix_nxt             = fix_r;
    tmp_nxt             = tmp_r;
    id_nxt              = id_r;
    per_nxt             = per_r;
    reins_nxt           = reins_r;
    st_nxt              = st_r;
    rv_nxt              = rv_r;
    rid_nxt             = rid_r;
    out_valid_nxt       = out_valid_r && !out_ready;
    out_status_nxt      = out_status_r;
    out_run_valid_nxt   = out_run_valid_r;
    out_run_task_id_nxt = out_run_task_id_r;
    out_task_count_nxt  = out_task_count_r;
    in_ready            = 1'b0;
    req                 = '0;
    wdata               = rd_data;
    alu_req.mode        = ALU_SUB;
    alu_req.a           = '0;
    alu_req.b           = '0;

    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          st_nxt    = ST_OK;
          rv_nxt    = 1'b0;
          rid_nxt   = '0;
          id_nxt    = ID_BITS'(in_task_id);
          per_nxt   = in_repeat_period;
          cur_nxt   = in_first_delay;
          reins_nxt = 1'b0;
          pos_nxt   = '0;
          unique case (in_opcode)
            OP_CLEAR: begin
              used_nxt  = '0;
              state_nxt = S_DONE;
            end
            OP_ADD: begin
              if (used_r >= CNT_W'(MAX_TASKS)) begin
                st_nxt    = ST_FULL;
                state_nxt = S_DONE;
              end else begin
                state_nxt = S_WALK_RD;
              end
            end
            OP_TICK: begin
              if (used_r == '0) begin
                st_nxt    = ST_NONE_DUE;
                state_nxt = S_DONE;
              end else begin
                state_nxt = S_TICK_RD;
              end
            end
            OP_DISPATCH: begin
              if (used_r == '0) begin
                st_nxt    = ST_NONE_DUE;
                state_nxt = S_DONE;
              end else begin
                state_nxt = S_DISP_RD;
              end
            end
            OP_DELETE: begin
              if (CNT_W'(in_slot_index) >= used_r) begin
                st_nxt    = ST_BAD_SLOT;
                state_nxt = S_DONE;
              end else begin
                pos_nxt   = CNT_W'(in_slot_index);
                state_nxt = S_RM_RD0;
              end
            end
            default: begin
              state_nxt = S_DONE;
            end
          endcase
        end
      end

      S_WALK_RD: begin
        if (pos_r == used_r) begin
          k_nxt     = used_r;
          state_nxt = S_SHIFT_RD;
        end else begin
          req.rd_en   = 1'b1;
          req.rd_addr = pos_r[IDX_W-1:0];
          state_nxt   = S_WALK_CHK;
        end
      end

      S_WALK_CHK: begin
        alu_req.a = cur_r;
        alu_req.b = rd_data.delta;
        if (!alu_borrow) begin
          cur_nxt   = alu_res;
          pos_nxt   = pos_p1;
          state_nxt = S_WALK_RD;
        end else begin
          state_nxt = S_FIX;
        end
      end

      S_FIX: begin
        alu_req.a = rd_data.delta;
        alu_req.b = cur_r;
        fix_nxt   = alu_res;
        k_nxt     = used_r;
        state_nxt = S_SHIFT_RD;
      end

      S_SHIFT_RD: begin
        if (k_r == pos_r) begin
          state_nxt = S_INS_WR;
        end else begin
          req.rd_en   = 1'b1;
          req.rd_addr = k_m1[IDX_W-1:0];
          state_nxt   = S_SHIFT_WR;
        end
      end

      S_SHIFT_WR: begin
        if (k_m1 == pos_r) begin
          wdata.delta = fix_r;
        end
        req.wr_en   = 1'b1;
        req.wr_addr = k_r[IDX_W-1:0];
        req.wr_data = wdata;
        k_nxt       = k_m1;
        state_nxt   = S_SHIFT_RD;
      end

      S_INS_WR: begin
        wdata.id      = id_r;
        wdata.delta   = cur_r;
        wdata.period  = per_r;
        wdata.pending = '0;
        req.wr_en     = 1'b1;
        req.wr_addr   = pos_r[IDX_W-1:0];
        req.wr_data   = wdata;
        used_nxt      = used_r + CNT_W'(1);
        state_nxt     = S_DONE;
      end

      S_TICK_RD: begin
        req.rd_en   = 1'b1;
        req.rd_addr = '0;
        state_nxt   = S_TICK_WR;
      end

      S_TICK_WR: begin
        alu_req.a = rd_data.delta;
        alu_req.b = DLY_W'(1);
        if (rd_data.delta != '0) begin
          wdata.delta = alu_res;
        end else if (rd_data.pending != PENDING_MAX) begin
          wdata.pending = rd_data.pending + PEND_W'(1);
        end
        req.wr_en   = 1'b1;
        req.wr_addr = '0;
        req.wr_data = wdata;
        state_nxt   = S_DONE;
      end

      S_DISP_RD: begin
        req.rd_en   = 1'b1;
        req.rd_addr = '0;
        state_nxt   = S_DISP_CHK;
      end

      S_DISP_CHK: begin
        if (rd_data.pending == '0) begin
          st_nxt    = ST_NONE_DUE;
          state_nxt = S_DONE;
        end else begin
          rv_nxt    = 1'b1;
          rid_nxt   = 8'(rd_data.id);
          id_nxt    = rd_data.id;
          per_nxt   = rd_data.period;
          reins_nxt = (rd_data.period != '0);
          pos_nxt   = '0;
          state_nxt = S_RM_RD0;
        end
      end

      S_RM_RD0: begin
        if (pos_p1 < used_r) begin
          req.rd_en   = 1'b1;
          req.rd_addr = pos_r[IDX_W-1:0];
          state_nxt   = S_RM_RD1;
        end else begin
          state_nxt = S_RM_END;
        end
      end

      S_RM_RD1: begin
        tmp_nxt     = rd_data.delta;
        req.rd_en   = 1'b1;
        req.rd_addr = pos_p1[IDX_W-1:0];
        state_nxt   = S_RM_SUM;
      end

      S_RM_SUM: begin
        alu_req.mode = ALU_ADD_SAT;
        alu_req.a    = tmp_r;
        alu_req.b    = rd_data.delta;
        fix_nxt      = alu_res;
        k_nxt        = pos_p1;
        state_nxt    = S_RM_SHRD;
      end

      S_RM_SHRD: begin
        if (k_r == used_r) begin
          state_nxt = S_RM_END;
        end else begin
          req.rd_en   = 1'b1;
          req.rd_addr = k_r[IDX_W-1:0];
          state_nxt   = S_RM_SHWR;
        end
      end

      S_RM_SHWR: begin
        if (k_r == pos_p1) begin
          wdata.delta = fix_r;
        end
        req.wr_en   = 1'b1;
        req.wr_addr = k_m1[IDX_W-1:0];
        req.wr_data = wdata;
        k_nxt       = k_r + CNT_W'(1);
        state_nxt   = S_RM_SHRD;
      end

      S_RM_END: begin
        used_nxt = used_r - CNT_W'(1);
        if (reins_r) begin
          cur_nxt   = per_r;
          pos_nxt   = '0;
          reins_nxt = 1'b0;
          state_nxt = S_WALK_RD;
        end else begin
          state_nxt = S_DONE;
        end
      end

      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt       = 1'b1;
          out_status_nxt      = st_r;
          out_run_valid_nxt   = rv_r;
          out_run_task_id_nxt = rid_r;
          out_task_count_nxt  = 5'(used_r);
          state_nxt           = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_run_valid   = out_run_valid_r;
  assign out_run_task_id = out_run_task_id_r;
  assign out_task_count  = out_task_count_r;

endmodule
`default_nettype wire

[sim/delta_list_task_scheduler_tb.sv]
// Self-checking testbench for the delta-list task scheduler, driven through valid/ready.
// Keeps its own copy of the task table to predict every result transaction.
// Depends on src/dlts_pkg.sv and src/delta_list_task_scheduler.sv.
`timescale 1ns / 1ps
module delta_list_task_scheduler_tb;
  import dlts_pkg::*;

  localparam logic [2:0] OP_SPARE_FIRST = 3'd5;
  localparam logic [2:0] OP_SPARE_LAST = 3'd7;
  localparam int CYCLE_LIMIT = 3_000_000;
  localparam int DRAIN_CYCLES = 100;
  localparam int RANDOM_ITEMS = 360;
  localparam int PENDING_TICKS = 12;

  typedef struct {
    status_t    status;
    logic       run_valid;
    logic [7:0] run_id;
    logic [4:0] count;
  } sched_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [2:0] in_opcode = '0;
  logic [7:0] in_task_id = '0;
  logic [31:0] in_first_delay = '0;
  logic [31:0] in_repeat_period = '0;
  logic [3:0] in_slot_index = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [1:0] out_status;
  logic out_run_valid;
  logic [7:0] out_run_task_id;
  logic [4:0] out_task_count;

  logic [7:0] list_id[MAX_TASKS];
  logic [31:0] list_delta[MAX_TASKS];
  logic [31:0] list_period[MAX_TASKS];
  logic [PEND_W-1:0] list_pend[MAX_TASKS];
  int list_used = 0;

  sched_result_t due_results[$];
  int fail_count = 0;
  int cycle_count = 0;
  int src_gap_max = 9;
  int sink_stall_max = 9;

  delta_list_task_scheduler u_top (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_opcode(in_opcode),
    .in_task_id(in_task_id),
    .in_first_delay(in_first_delay),
    .in_repeat_period(in_repeat_period),
    .in_slot_index(in_slot_index),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_status(out_status),
    .out_run_valid(out_run_valid),
    .out_run_task_id(out_run_task_id),
    .out_task_count(out_task_count)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  function automatic bit list_insert(logic [7:0] id, logic [31:0] delay, logic [31:0] period);
    int pos;
    int k;
    if (list_used >= MAX_TASKS) return 1'b0;
    pos = 0;
    while (pos < list_used && delay >= list_delta[pos]) begin
      delay -= list_delta[pos];
      pos++;
    end
    for (k = list_used; k > pos; k--) begin
      list_id[k] = list_id[k-1];
      list_delta[k] = list_delta[k-1];
      list_period[k] = list_period[k-1];
      list_pend[k] = list_pend[k-1];
    end
    if (pos < list_used) list_delta[pos+1] -= delay;
    list_id[pos] = id;
    list_delta[pos] = delay;
    list_period[pos] = period;
    list_pend[pos] = '0;
    list_used++;
    return 1'b1;
  endfunction

  function automatic void list_remove(int slot);
    logic [32:0] sum;
    int k;
    if (slot + 1 < list_used) begin
      sum = {1'b0, list_delta[slot+1]} + {1'b0, list_delta[slot]};
      list_delta[slot+1] = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
    end
    for (k = slot + 1; k < list_used; k++) begin
      list_id[k-1] = list_id[k];
      list_delta[k-1] = list_delta[k];
      list_period[k-1] = list_period[k];
      list_pend[k-1] = list_pend[k];
    end
    list_used--;
  endfunction

  function automatic sched_result_t schedule_step(logic [2:0] op, logic [7:0] id,
                                                  logic [31:0] delay, logic [31:0] period,
                                                  logic [3:0] slot);
    sched_result_t r;
    logic [7:0] head_id;
    logic [31:0] head_period;
    r.status = ST_OK;
    r.run_valid = 1'b0;
    r.run_id = '0;
    case (op)
      OP_CLEAR: begin
        list_used = 0;
      end
      OP_ADD: begin
        if (!list_insert(id, delay, period)) r.status = ST_FULL;
      end
      OP_TICK: begin
        if (list_used == 0) r.status = ST_NONE_DUE;
        else if (list_delta[0] != 0) list_delta[0]--;
        else if (list_pend[0] != PENDING_MAX) list_pend[0]++;
      end
      OP_DISPATCH: begin
        if (list_used == 0 || list_pend[0] == 0) begin
          r.status = ST_NONE_DUE;
        end else begin
          head_id = list_id[0];
          head_period = list_period[0];
          r.run_valid = 1'b1;
          r.run_id = head_id;
          list_remove(0);
          if (head_period != 0) void'(list_insert(head_id, head_period, head_period));
        end
      end
      OP_DELETE: begin
        if (int'(slot) >= list_used) r.status = ST_BAD_SLOT;
        else list_remove(int'(slot));
      end
      default: begin
      end
    endcase
    r.count = list_used[4:0];
    return r;
  endfunction

  task automatic issue_command(input logic [2:0] op, input logic [7:0] id = '0,
                               input logic [31:0] delay = '0, input logic [31:0] period = '0,
                               input logic [3:0] slot = '0);
    int gap;
    gap = $urandom_range(src_gap_max, 0);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_opcode <= op;
    in_task_id <= id;
    in_first_delay <= delay;
    in_repeat_period <= period;
    in_slot_index <= slot;
    do @(posedge clk); while (!in_ready);
    due_results.push_back(schedule_step(op, id, delay, period, slot));
  endtask

  initial begin : result_monitor
    sched_result_t exp;
    int stall;
    wait (rst_n === 1'b1);
    forever begin
      stall = $urandom_range(sink_stall_max, 0);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (out_valid !== 1'b1);
      if (due_results.size() == 0) begin
        $error("result transaction with no expectation pending");
        fail_count++;
      end else begin
        exp = due_results.pop_front();
        if (out_status !== exp.status) begin
          $error("status expected %0d got %0d", exp.status, out_status);
          fail_count++;
        end
        if (out_run_valid !== exp.run_valid) begin
          $error("run_valid expected %0d got %0d", exp.run_valid, out_run_valid);
          fail_count++;
        end
        if (out_run_task_id !== exp.run_id) begin
          $error("run_task_id expected %0d got %0d", exp.run_id, out_run_task_id);
          fail_count++;
        end
        if (out_task_count !== exp.count) begin
          $error("task_count expected %0d got %0d", exp.count, out_task_count);
          fail_count++;
        end
      end
    end
  end

  function automatic logic [31:0] pick_delay();
    int r;
    r = $urandom_range(9, 0);
    if (r == 0) return $urandom();
    if (r == 1) return $urandom_range(1, 0) ? 32'hFFFF_FFFF : 32'h0;
    return $urandom_range(6, 0);
  endfunction

  function automatic logic [31:0] pick_period();
    int r;
    r = $urandom_range(19, 0);
    if (r == 0) return $urandom();
    if (r == 1) return 32'hFFFF_FFFF;
    if (r < 8) return 32'h0;
    return $urandom_range(5, 1);
  endfunction

  task automatic test_empty_table();
    int op;
    issue_command(OP_CLEAR);
    issue_command(OP_TICK);
    issue_command(OP_DISPATCH);
    issue_command(OP_DELETE, '0, '0, '0, 4'd0);
    issue_command(OP_DELETE, '0, '0, '0, 4'd15);
    for (op = OP_SPARE_FIRST; op <= OP_SPARE_LAST; op++)
      issue_command(op[2:0], 8'($urandom()), $urandom(), $urandom(), 4'($urandom()));
  endtask

  task automatic test_add_extremes();
    issue_command(OP_ADD, 8'hFF, 32'h0, 32'hFFFF_FFFF);
    issue_command(OP_ADD, 8'h00, 32'hFFFF_FFFF, 32'h0);
    issue_command(OP_ADD, 8'hA5, 32'h0, 32'h0);
    issue_command(OP_TICK);
    issue_command(OP_TICK);
    issue_command(OP_DISPATCH);
    issue_command(OP_DISPATCH);
    issue_command(OP_TICK);
    issue_command(OP_DISPATCH);
    issue_command(OP_DELETE, '0, '0, '0, 4'd1);
    issue_command(OP_DELETE, '0, '0, '0, 4'd2);
    issue_command(OP_DELETE, '0, '0, '0, 4'd0);
    issue_command(OP_CLEAR);
  endtask

  task automatic test_full_table();
    int i;
    issue_command(OP_CLEAR);
    for (i = 0; i <= MAX_TASKS; i++)
      issue_command(OP_ADD, 8'($urandom()), pick_delay(), pick_period());
    issue_command(OP_DELETE, '0, '0, '0, 4'd15);
    issue_command(OP_ADD, 8'($urandom()), pick_delay(), pick_period());
    for (i = 0; i < 6; i++)
      issue_command(OP_DELETE, '0, '0, '0, 4'($urandom_range(list_used - 1, 0)));
    issue_command(OP_CLEAR);
  endtask

  task automatic test_pending_runs();
    int i;
    src_gap_max = 0;
    sink_stall_max = 0;
    issue_command(OP_CLEAR);
    issue_command(OP_ADD, 8'h3C, 32'h0, 32'd3);
    for (i = 0; i < PENDING_TICKS; i++) issue_command(OP_TICK);
    issue_command(OP_DISPATCH);
    issue_command(OP_DISPATCH);
    issue_command(OP_CLEAR);
    src_gap_max = 9;
    sink_stall_max = 9;
  endtask

  task automatic test_random_schedule();
    int i;
    int pick;
    for (i = 0; i < RANDOM_ITEMS; i++) begin
      if (i % 40 == 0) begin
        src_gap_max = $urandom_range(3, 0) == 0 ? 0 : 9;
        sink_stall_max = $urandom_range(3, 0) == 0 ? 0 : 9;
      end
      pick = $urandom_range(99, 0);
      if (pick < 32)
        issue_command(OP_ADD, 8'($urandom()), pick_delay(), pick_period());
      else if (pick < 66)
        issue_command(OP_TICK, 8'($urandom()), $urandom(), $urandom(), 4'($urandom()));
      else if (pick < 86)
        issue_command(OP_DISPATCH, 8'($urandom()), $urandom(), $urandom(), 4'($urandom()));
      else if (pick < 94)
        issue_command(OP_DELETE, 8'($urandom()), $urandom(), $urandom(),
                      4'((list_used > 0 && $urandom_range(3, 0) != 0) ?
                         $urandom_range(list_used - 1, 0) : $urandom_range(15, 0)));
      else if (pick < 96)
        issue_command(OP_CLEAR, 8'($urandom()), $urandom(), $urandom(), 4'($urandom()));
      else
        issue_command(3'($urandom_range(OP_SPARE_LAST, OP_SPARE_FIRST)), 8'($urandom()),
                      $urandom(), $urandom(), 4'($urandom()));
    end
    src_gap_max = 9;
    sink_stall_max = 9;
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_empty_table();
    test_add_extremes();
    test_full_table();
    test_random_schedule();
    test_pending_runs();
    test_full_table();
    in_valid <= 1'b0;
    while (due_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

endmodule
